// ===== hw/rtl/sdsc_pkg.sv =====
// sdsc_pkg.sv: shared types and constants of the sd spi command sequencer
`timescale 1ns / 1ps

package sdsc_pkg;

  // default command store depth and register reset values
  localparam int CmdDepthDefault = 8;
  localparam logic [15:0] PollLimitReset = 16'd500;

  // byte codes on the spi line
  localparam logic [7:0] PollByte   = 8'hff;
  localparam logic [7:0] StartToken = 8'hfe;
  localparam logic [7:0] BusyMask   = 8'h80;

  // item opcodes
  localparam logic [2:0] OpLoad   = 3'd0;
  localparam logic [2:0] OpStart  = 3'd1;
  localparam logic [2:0] OpRx     = 3'd2;
  localparam logic [2:0] OpResume = 3'd3;
  localparam logic [2:0] OpFinish = 3'd4;

  // configuration register indexes
  localparam logic CfgAckLimit   = 1'b0;
  localparam logic CfgTokenLimit = 1'b1;

  // transaction phases
  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhSend    = 3'd1;
  localparam logic [2:0] PhAck     = 3'd2;
  localparam logic [2:0] PhToken   = 3'd3;
  localparam logic [2:0] PhRead    = 3'd4;
  localparam logic [2:0] PhWaitBuf = 3'd5;

  // one input item
  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  cmd_slot;
    logic [7:0]  cmd_value;
    logic [3:0]  cmd_length;
    logic [7:0]  expected_response;
    logic [15:0] grant_length;
    logic [7:0]  rx_value;
  } item_t;

  // one result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_value;
    logic       data_valid;
    logic [7:0] data_value;
    logic       select_level;
    logic       finished;
    logic       failed;
    logic       need_buffer;
  } result_t;

endpackage

// ===== hw/rtl/sdsc_in_if.sv =====
// sdsc_in_if.sv: input item channel of the sd spi command sequencer
`timescale 1ns / 1ps

interface sdsc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  cmd_slot;
  logic [7:0]  cmd_value;
  logic [3:0]  cmd_length;
  logic [7:0]  expected_response;
  logic [15:0] grant_length;
  logic [7:0]  rx_value;

  modport source (
    output valid, opcode, cmd_slot, cmd_value, cmd_length, expected_response,
    output grant_length, rx_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, cmd_slot, cmd_value, cmd_length, expected_response,
    input  grant_length, rx_value,
    output ready
  );
endinterface

// ===== hw/rtl/sdsc_out_if.sv =====
// sdsc_out_if.sv: result item channel of the sd spi command sequencer
`timescale 1ns / 1ps

interface sdsc_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_value;
  logic       data_valid;
  logic [7:0] data_value;
  logic       select_level;
  logic       finished;
  logic       failed;
  logic       need_buffer;

  modport source (
    output valid, tx_valid, tx_value, data_valid, data_value, select_level,
    output finished, failed, need_buffer,
    input  ready
  );

  modport sink (
    input  valid, tx_valid, tx_value, data_valid, data_value, select_level,
    input  finished, failed, need_buffer,
    output ready
  );
endinterface

// ===== hw/rtl/sdsc_cmd_store.sv =====
// sdsc_cmd_store.sv: command byte store, written by load items
`timescale 1ns / 1ps

module sdsc_cmd_store
  import sdsc_pkg::*;
#(
  parameter int CMD_DEPTH = CmdDepthDefault,
  localparam int IdxW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [2:0]      wr_slot,
  input  logic [7:0]      wr_data,
  input  logic [IdxW-1:0] rd_idx,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [CMD_DEPTH];
  logic [4:0] slot_wide;
  logic       slot_ok;

  // slots at or beyond the depth are dropped
  assign slot_wide = {2'b00, wr_slot};
  assign slot_ok   = slot_wide < 5'(CMD_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && slot_ok) begin
      mem[slot_wide[IdxW-1:0]] <= wr_data;
    end
  end

  assign rd_data = mem[rd_idx];

endmodule

// ===== hw/rtl/sdsc_ctrl.sv =====
// sdsc_ctrl.sv: transaction phase, counters and per-item decision logic
`timescale 1ns / 1ps

module sdsc_ctrl
  import sdsc_pkg::*;
#(
  parameter int CMD_DEPTH = CmdDepthDefault,
  localparam int IdxW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1,
  localparam int CntW = $clog2(CMD_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  item_t           item,
  input  logic [15:0]     ack_limit,
  input  logic [15:0]     token_limit,
  input  logic [7:0]      store_data,
  output logic [IdxW-1:0] store_idx,
  output result_t         res
);

  logic [2:0]      phase, phase_next;
  logic [CntW-1:0] send_position, send_position_next;
  logic [CntW-1:0] send_count, send_count_next;
  logic [7:0]      awaited_code, awaited_code_next;
  logic [15:0]     bytes_remaining, bytes_remaining_next;
  logic [15:0]     ack_polls_left, ack_polls_left_next;
  logic [15:0]     token_polls_left, token_polls_left_next;
  logic            select_reg, select_reg_next;

  logic [4:0]      len_wide;
  logic [4:0]      len_clamped;
  logic [CntW-1:0] pos_base;
  logic [CntW-1:0] pos_clamped;
  logic [CntW-1:0] pos_inc;
  logic [CntW-1:0] cnt_cur;
  logic [7:0]      tok_rx;
  logic [15:0]     bytes_dec;

  // command length clamped to 1..depth
  assign len_wide = {1'b0, item.cmd_length};
  always_comb begin
    len_clamped = len_wide;
    if (len_wide == 5'd0) begin
      len_clamped = 5'd1;
    end
    if (len_wide > 5'(CMD_DEPTH)) begin
      len_clamped = 5'(CMD_DEPTH);
    end
  end

  // send position, restarted by a start item
  assign pos_base    = (item.opcode == OpStart) ? '0 : send_position;
  assign pos_clamped = (pos_base >= CntW'(CMD_DEPTH)) ? CntW'(CMD_DEPTH - 1) : pos_base;
  assign pos_inc     = pos_clamped + CntW'(1);
  assign cnt_cur     = (item.opcode == OpStart) ? len_clamped[CntW-1:0] : send_count;
  assign store_idx   = pos_clamped[IdxW-1:0];

  // a matched response acts as a poll byte seen in token wait
  assign tok_rx    = (phase == PhAck) ? PollByte : item.rx_value;
  assign bytes_dec = (bytes_remaining != 16'd0) ? bytes_remaining - 16'd1 : 16'd0;

  // per-item decision
  always_comb begin
    phase_next            = phase;
    send_position_next    = send_position;
    send_count_next       = send_count;
    awaited_code_next     = awaited_code;
    bytes_remaining_next  = bytes_remaining;
    ack_polls_left_next   = ack_polls_left;
    token_polls_left_next = token_polls_left;
    select_reg_next       = select_reg;
    res                   = '0;

    unique case (item.opcode)
      OpStart: begin
        send_count_next       = cnt_cur;
        awaited_code_next     = item.expected_response;
        bytes_remaining_next  = item.grant_length;
        ack_polls_left_next   = ack_limit;
        token_polls_left_next = token_limit;
        select_reg_next       = 1'b1;
        res.tx_valid          = 1'b1;
        res.tx_value          = store_data;
        send_position_next    = pos_inc;
        phase_next            = (pos_inc >= cnt_cur) ? PhAck : PhSend;
      end
      OpRx: begin
        if (phase == PhSend) begin
          res.tx_valid       = 1'b1;
          res.tx_value       = store_data;
          send_position_next = pos_inc;
          if (pos_inc >= cnt_cur) begin
            phase_next = PhAck;
          end
        end else if ((phase == PhAck && item.rx_value == awaited_code) ||
                     phase == PhToken) begin
          // token wait
          phase_next = PhToken;
          if (bytes_remaining == 16'd0) begin
            select_reg_next = 1'b0;
            phase_next      = PhIdle;
            res.finished    = 1'b1;
          end else if (tok_rx == StartToken) begin
            phase_next   = PhRead;
            res.tx_valid = 1'b1;
            res.tx_value = PollByte;
          end else if (token_polls_left == 16'd0 || (tok_rx & BusyMask) == 8'd0) begin
            select_reg_next = 1'b0;
            phase_next      = PhIdle;
            res.finished    = 1'b1;
            res.failed      = 1'b1;
          end else begin
            res.tx_valid          = 1'b1;
            res.tx_value          = PollByte;
            token_polls_left_next = token_polls_left - 16'd1;
          end
        end else if (phase == PhAck) begin
          if (ack_polls_left == 16'd0 || (item.rx_value & BusyMask) == 8'd0) begin
            select_reg_next = 1'b0;
            phase_next      = PhIdle;
            res.finished    = 1'b1;
            res.failed      = 1'b1;
          end else begin
            res.tx_valid        = 1'b1;
            res.tx_value        = PollByte;
            ack_polls_left_next = ack_polls_left - 16'd1;
          end
        end else if (phase == PhRead) begin
          res.data_valid       = 1'b1;
          res.data_value       = item.rx_value;
          bytes_remaining_next = bytes_dec;
          if (bytes_dec != 16'd0) begin
            res.tx_valid = 1'b1;
            res.tx_value = PollByte;
          end else begin
            phase_next      = PhWaitBuf;
            res.need_buffer = 1'b1;
          end
        end
      end
      OpResume: begin
        if (phase == PhWaitBuf) begin
          bytes_remaining_next = item.grant_length;
          if (item.grant_length == 16'd0) begin
            res.need_buffer = 1'b1;
          end else begin
            phase_next   = PhRead;
            res.tx_valid = 1'b1;
            res.tx_value = PollByte;
          end
        end
      end
      OpFinish: begin
        if (phase != PhIdle) begin
          select_reg_next = 1'b0;
          phase_next      = PhIdle;
          res.finished    = 1'b1;
        end
      end
      default: begin
        // loads touch only the store; other codes are ignored
      end
    endcase

    res.select_level = select_reg_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PhIdle;
      send_position    <= '0;
      send_count       <= '0;
      awaited_code     <= '0;
      bytes_remaining  <= '0;
      ack_polls_left   <= '0;
      token_polls_left <= '0;
      select_reg       <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      send_position    <= send_position_next;
      send_count       <= send_count_next;
      awaited_code     <= awaited_code_next;
      bytes_remaining  <= bytes_remaining_next;
      ack_polls_left   <= ack_polls_left_next;
      token_polls_left <= token_polls_left_next;
      select_reg       <= select_reg_next;
    end
  end

endmodule

// ===== hw/rtl/sd_spi_command_sequencer.sv =====
// An accepted item passes the input register, then the result register,
// to give its result item. Throughput: one item per cycle while out_ch
// keeps taking results; the per-item decision sits between the two registers.
// Reset (synchronous, active high) leaves the block idle with chip select
// released and both poll limits at 500; the command store is not reset.
`timescale 1ns / 1ps

module sd_spi_command_sequencer
  import sdsc_pkg::*;
#(
  parameter int CMD_DEPTH = CmdDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  sdsc_in_if.sink     in_ch,
  sdsc_out_if.source  out_ch
);

  localparam int IdxW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

  logic [15:0]     ack_limit;
  logic [15:0]     token_limit;
  logic            s1_valid;
  item_t           s1_item;
  logic            fire;
  logic            out_valid;
  result_t         out_res;
  result_t         res;
  logic [IdxW-1:0] store_idx;
  logic [7:0]      store_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_limit   <= PollLimitReset;
      token_limit <= PollLimitReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgAckLimit:   ack_limit   <= cfg_data;
        CfgTokenLimit: token_limit <= cfg_data;
        default:       ack_limit   <= ack_limit;
      endcase
    end
  end

  // handshake: the input stage moves on when the result register frees up
  assign fire        = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item.opcode            <= in_ch.opcode;
      s1_item.cmd_slot          <= in_ch.cmd_slot;
      s1_item.cmd_value         <= in_ch.cmd_value;
      s1_item.cmd_length        <= in_ch.cmd_length;
      s1_item.expected_response <= in_ch.expected_response;
      s1_item.grant_length      <= in_ch.grant_length;
      s1_item.rx_value          <= in_ch.rx_value;
    end
  end

  // command byte store
  sdsc_cmd_store #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (fire && s1_item.opcode == OpLoad),
    .wr_slot(s1_item.cmd_slot),
    .wr_data(s1_item.cmd_value),
    .rd_idx (store_idx),
    .rd_data(store_data)
  );

  // transaction control
  sdsc_ctrl #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (s1_item),
    .ack_limit  (ack_limit),
    .token_limit(token_limit),
    .store_data (store_data),
    .store_idx  (store_idx),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.tx_valid     = out_res.tx_valid;
  assign out_ch.tx_value     = out_res.tx_value;
  assign out_ch.data_valid   = out_res.data_valid;
  assign out_ch.data_value   = out_res.data_value;
  assign out_ch.select_level = out_res.select_level;
  assign out_ch.finished     = out_res.finished;
  assign out_ch.failed       = out_res.failed;
  assign out_ch.need_buffer  = out_res.need_buffer;

endmodule
